// File: rtl/srr_pkg.sv
package srr_pkg;

  // result kinds on the output channel
  localparam logic KIND_ACK = 1'b0;
  localparam logic KIND_DLV = 1'b1;

  // control of the slot payload memory
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } ram_ctl_t;

endpackage

// File: rtl/srr_slot_ram.sv
module srr_slot_ram #(
  parameter int DEPTH = 4,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  srr_pkg::ram_ctl_t        ctl,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  import srr_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, same-cycle write to the same slot forwarded
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      if (ctl.wr_en && (wr_addr == rd_addr)) begin
        rd_data_r <= wr_data;
      end else begin
        rd_data_r <= mem[rd_addr];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/selective_repeat_receiver.sv
// Timing: a good packet's beat is captured and the sequencer enters its ack state;
// the ack and each in-order delivery after it are registered once the output is free.
// Throughput: a good packet yields an ack and up to SEQ_SPACE/2 deliveries, one slot read
// each, with in_stall high until its last result; a corrupt packet yields no result.
// Reset: window base goes to zero and all fill marks clear at once; the slot payload
// memory is not cleared and is only read for filled slots.
module selective_repeat_receiver #(
  parameter int SEQ_SPACE    = 8,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [$clog2(SEQ_SPACE)-1:0] in_seq_num,
  input  logic                         in_checksum_ok,
  input  logic [PAYLOAD_BITS-1:0]      in_payload_word,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_result_kind,
  output logic [$clog2(SEQ_SPACE)-1:0] out_ack_number,
  output logic [PAYLOAD_BITS-1:0]      out_delivered_word,
  output logic                         out_last_of_run
);
  import srr_pkg::*;

  localparam int SEQ_W  = $clog2(SEQ_SPACE);
  localparam int WIN    = SEQ_SPACE / 2;
  localparam int SLOT_W = $clog2(WIN);

  localparam logic [SEQ_W:0]    SPACE_X   = (SEQ_W+1)'(SEQ_SPACE);
  localparam logic [SEQ_W:0]    WIN_X     = (SEQ_W+1)'(WIN);
  localparam logic [SEQ_W-1:0]  BASE_LAST = SEQ_W'(SEQ_SPACE - 1);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WIN - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ACK  = 2'd1;
  localparam logic [1:0] ST_DLV  = 2'd2;

  logic [1:0]              state_r, state_nxt;
  logic [SEQ_W-1:0]        seq_r;
  logic [PAYLOAD_BITS-1:0] pay_r;
  logic [SEQ_W-1:0]        base_r, base_nxt;
  logic [WIN-1:0]          filled_r, filled_nxt;

  logic                    out_valid_r;
  logic                    kind_r, kind_nxt;
  logic [SEQ_W-1:0]        ack_r, ack_nxt;
  logic [PAYLOAD_BITS-1:0] word_r, word_nxt;
  logic                    last_r, last_nxt;

  logic [SEQ_W:0]          seq_in_x, seq_red, seq_x, base_x, off_x, wslot_x, bslot_x;
  logic [SLOT_W-1:0]       wslot, bslot, nslot, rd_addr;
  logic [SEQ_W-1:0]        base_adv;
  logic                    in_win, head_fill, out_free, emit;
  ram_ctl_t                ram_ctl;
  logic [PAYLOAD_BITS-1:0] rd_data;

  // sequence reduction, window offset and slot numbers
  always_comb begin
    seq_in_x = {1'b0, in_seq_num};
    seq_red  = (seq_in_x >= SPACE_X) ? (seq_in_x - SPACE_X) : seq_in_x;
    seq_x    = {1'b0, seq_r};
    base_x   = {1'b0, base_r};
    off_x    = (seq_r >= base_r) ? (seq_x - base_x) : (seq_x + SPACE_X - base_x);
    in_win   = (off_x < WIN_X);
    wslot_x  = (seq_x >= WIN_X) ? (seq_x - WIN_X) : seq_x;
    bslot_x  = (base_x >= WIN_X) ? (base_x - WIN_X) : base_x;
    wslot    = wslot_x[SLOT_W-1:0];
    bslot    = bslot_x[SLOT_W-1:0];
    nslot    = (bslot == SLOT_LAST) ? '0 : bslot + 1'b1;
    base_adv = (base_r == BASE_LAST) ? '0 : base_r + 1'b1;
    head_fill = filled_r[bslot] || (in_win && (wslot == bslot));
  end

  assign out_free = !out_valid_r || !out_stall;

  // sequencer: ack, then one delivery per memory read
  always_comb begin
    state_nxt  = state_r;
    base_nxt   = base_r;
    filled_nxt = filled_r;
    emit       = 1'b0;
    kind_nxt   = KIND_ACK;
    ack_nxt    = '0;
    word_nxt   = '0;
    last_nxt   = 1'b0;
    ram_ctl    = '0;
    rd_addr    = bslot;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_checksum_ok) begin
          state_nxt = ST_ACK;
        end
      end
      ST_ACK: begin
        if (out_free) begin
          emit     = 1'b1;
          kind_nxt = KIND_ACK;
          ack_nxt  = seq_r;
          last_nxt = !(in_win && head_fill);
          if (in_win) begin
            ram_ctl.wr_en     = 1'b1;
            filled_nxt[wslot] = 1'b1;
          end
          if (last_nxt) begin
            state_nxt = ST_IDLE;
          end else begin
            ram_ctl.rd_en = 1'b1;
            rd_addr       = bslot;
            state_nxt     = ST_DLV;
          end
        end
      end
      ST_DLV: begin
        if (out_free) begin
          emit              = 1'b1;
          kind_nxt          = KIND_DLV;
          word_nxt          = rd_data;
          filled_nxt[bslot] = 1'b0;
          base_nxt          = base_adv;
          last_nxt          = !filled_r[nslot];
          if (last_nxt) begin
            state_nxt = ST_IDLE;
          end else begin
            ram_ctl.rd_en = 1'b1;
            rd_addr       = nslot;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_stall = (state_r != ST_IDLE);

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      base_r      <= '0;
      filled_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      base_r   <= base_nxt;
      filled_r <= filled_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // captured input beat
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      seq_r <= seq_red[SEQ_W-1:0];
      pay_r <= in_payload_word;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (emit) begin
      kind_r <= kind_nxt;
      ack_r  <= ack_nxt;
      word_r <= word_nxt;
      last_r <= last_nxt;
    end
  end

  srr_slot_ram #(
    .DEPTH (WIN),
    .WIDTH (PAYLOAD_BITS)
  ) u_slot_ram (
    .clk     (clk),
    .ctl     (ram_ctl),
    .wr_addr (wslot),
    .wr_data (pay_r),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_valid          = out_valid_r;
  assign out_result_kind    = kind_r;
  assign out_ack_number     = ack_r;
  assign out_delivered_word = word_r;
  assign out_last_of_run    = last_r;

  // a delivery always comes from a filled slot
  a_dlv_filled: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DLV && out_free) |-> filled_r[bslot])
    else $error("delivery from an empty slot");

  // the final result of a packet returns the sequencer to idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && last_nxt) |=> (state_r == ST_IDLE))
    else $error("sequencer busy after last result");

  // between packets the slot at the window base is never left filled
  a_base_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !filled_r[bslot])
    else $error("in-order run left undelivered");

endmodule

// File: sim/selective_repeat_receiver_test.sv
module selective_repeat_receiver_test;
  import srr_pkg::*;

  localparam int SEQ_SPACE = 8;
  localparam int PAY_W     = 32;
  localparam int WIN       = SEQ_SPACE / 2;
  localparam int GOOD_PER_PHASE = 104;

  typedef struct packed {
    logic             kind;
    logic [2:0]       ack_number;
    logic [PAY_W-1:0] delivered_word;
    logic             last_of_run;
  } arq_result_t;

  // receive window tracker: predicts acks and in-order deliveries
  class arq_window_tracker;
    logic [2:0]       window_base;
    logic             slot_filled [WIN];
    logic [PAY_W-1:0] slot_payload [WIN];
    arq_result_t      pending_results [$];
    int               mismatches;

    function new();
      window_base = '0;
      foreach (slot_filled[i]) slot_filled[i] = 1'b0;
      mismatches = 0;
    endfunction

    function void take_packet(logic [2:0] seq, logic ok, logic [PAY_W-1:0] word);
      arq_result_t r;
      logic [2:0]  offset;
      if (!ok) return;
      offset = seq - window_base;
      r = '{kind: KIND_ACK, ack_number: seq, delivered_word: '0, last_of_run: 1'b0};
      pending_results.push_back(r);
      // inside the window: store, then release the in-order run from base
      if (offset < WIN) begin
        slot_payload[seq[1:0]] = word;
        slot_filled[seq[1:0]]  = 1'b1;
        while (slot_filled[window_base[1:0]]) begin
          r = '{kind: KIND_DLV, ack_number: 3'd0,
                delivered_word: slot_payload[window_base[1:0]], last_of_run: 1'b0};
          pending_results.push_back(r);
          slot_filled[window_base[1:0]] = 1'b0;
          window_base = window_base + 3'd1;
        end
      end
      pending_results[pending_results.size()-1].last_of_run = 1'b1;
    endfunction

    function void match_result(arq_result_t got);
      arq_result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: kind %0b ack %0d word %08h last %0b",
                 $time, got.kind, got.ack_number, got.delivered_word, got.last_of_run);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      if (got.kind !== want.kind) begin
        $display("%0t: result_kind expected %0b actual %0b", $time, want.kind, got.kind);
        mismatches++;
      end
      if (got.ack_number !== want.ack_number) begin
        $display("%0t: ack_number expected %0d actual %0d",
                 $time, want.ack_number, got.ack_number);
        mismatches++;
      end
      if (got.delivered_word !== want.delivered_word) begin
        $display("%0t: delivered_word expected %08h actual %08h",
                 $time, want.delivered_word, got.delivered_word);
        mismatches++;
      end
      if (got.last_of_run !== want.last_of_run) begin
        $display("%0t: last_of_run expected %0b actual %0b",
                 $time, want.last_of_run, got.last_of_run);
        mismatches++;
      end
    endfunction
  endclass

  logic             clk;
  logic             rst_n           = 1'b0;
  logic             in_valid        = 1'b0;
  logic             in_stall;
  logic [2:0]       in_seq_num      = '0;
  logic             in_checksum_ok  = 1'b0;
  logic [PAY_W-1:0] in_payload_word = '0;
  logic             out_valid;
  logic             out_stall       = 1'b0;
  logic             out_result_kind;
  logic [2:0]       out_ack_number;
  logic [PAY_W-1:0] out_delivered_word;
  logic             out_last_of_run;

  int unsigned in_idle_pct   = 0;
  int unsigned out_stall_pct = 0;
  int          good_sent;

  arq_window_tracker tracker;

  selective_repeat_receiver #(
    .SEQ_SPACE   (SEQ_SPACE),
    .PAYLOAD_BITS(PAY_W)
  ) u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_seq_num        (in_seq_num),
    .in_checksum_ok    (in_checksum_ok),
    .in_payload_word   (in_payload_word),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_result_kind   (out_result_kind),
    .out_ack_number    (out_ack_number),
    .out_delivered_word(out_delivered_word),
    .out_last_of_run   (out_last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < out_stall_pct);
  end

  // result beat monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      tracker.match_result('{kind: out_result_kind, ack_number: out_ack_number,
                             delivered_word: out_delivered_word,
                             last_of_run: out_last_of_run});
  end

  // one packet beat, with random idle cycles in front
  task automatic send_packet(input logic [2:0] seq, input logic ok,
                             input logic [PAY_W-1:0] word);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_seq_num      <= seq;
    in_checksum_ok  <= ok;
    in_payload_word <= word;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.take_packet(seq, ok, word);
    if (ok) good_sent++;
  endtask

  // mostly packets inside the current window, some stale, some corrupt
  task automatic send_random_packet();
    int unsigned      pick;
    logic [2:0]       seq;
    logic             ok;
    logic [PAY_W-1:0] word;
    pick = $urandom_range(0, 99);
    ok   = 1'b1;
    if (pick < 68) begin
      seq = tracker.window_base + 3'($urandom_range(0, WIN - 1));
    end else if (pick < 78) begin
      seq = 3'($urandom_range(0, SEQ_SPACE - 1));
      ok  = 1'b0;
    end else if (pick < 93) begin
      seq = tracker.window_base - 3'($urandom_range(1, WIN));
    end else begin
      seq = 3'($urandom_range(0, SEQ_SPACE - 1));
    end
    case ($urandom_range(0, 19))
      0:       word = '0;
      1:       word = '1;
      default: word = $urandom;
    endcase
    send_packet(seq, ok, word);
  endtask

  task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct);
    int target;
    in_idle_pct   = idle_pct;
    out_stall_pct = stall_pct;
    target        = good_sent + GOOD_PER_PHASE;
    while (good_sent < target) send_random_packet();
  endtask

  initial begin
    tracker   = new();
    good_sent = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    in_idle_pct   = 28;
    out_stall_pct = 62;
    // corrupt packet, then a single in-order delivery
    send_packet(3'd0, 1'b0, 32'hffff_ffff);
    send_packet(3'd0, 1'b1, 32'h0000_0000);
    // out of order fill with a duplicate, then the base slot releases four
    send_packet(3'd4, 1'b1, 32'hffff_ffff);
    send_packet(3'd3, 1'b1, 32'haaaa_aaaa);
    send_packet(3'd2, 1'b1, 32'h5555_5555);
    send_packet(3'd3, 1'b1, 32'h1234_5678);
    send_packet(3'd1, 1'b1, 32'h8000_0001);
    // stale packets just below and just beyond the window
    send_packet(3'd4, 1'b1, 32'hdead_beef);
    send_packet(3'd1, 1'b1, 32'hcafe_f00d);
    // window wraps through zero
    send_packet(3'd7, 1'b1, 32'h0000_0007);
    send_packet(3'd0, 1'b1, 32'h0000_0100);
    send_packet(3'd7, 1'b0, 32'h7777_7777);
    send_packet(3'd6, 1'b1, 32'h0000_0006);
    send_packet(3'd5, 1'b1, 32'h0000_0005);
    send_packet(3'd1, 1'b0, 32'h1111_1111);
    send_packet(3'd1, 1'b1, 32'h7fff_fffe);
    send_packet(3'd5, 1'b1, 32'h0f0f_0f0f);
    send_packet(3'd2, 1'b1, 32'hf0f0_f0f0);

    run_phase(28, 62);
    run_phase(62, 28);
    run_phase(0, 0);
    in_valid <= 1'b0;

    // drain, then watch for stray beats
    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending_results.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #3000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
